// ----- design/hcte_pkg.sv -----
`timescale 1ns / 1ps

package hcte_pkg;

	localparam int SYM_W  = 8;
	localparam int WORD_W = 32;
	localparam int LEN_W  = 6;
	localparam int PEND_W = 7;
	localparam int PCNT_W = 3;
	localparam int BYTE_W = 8;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_ENCODE = 2'd1,
		FUNC_FLUSH  = 2'd2
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [SYM_W-1:0]   symbol;
		logic [WORD_W-1:0]  code_word;
		logic [LEN_W-1:0]   code_length;
	} in_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic               last;
	} out_t;

	// Item after the table lookup, handed from the table stage to the packer.
	typedef struct packed {
		func_t              func;
		logic               hit;
		logic [LEN_W-1:0]   len;
		logic [WORD_W-1:0]  word;
	} item_t;

endpackage

// ----- design/hcte_table.sv -----
`timescale 1ns / 1ps

module hcte_table
	import hcte_pkg::*;
#(
	parameter int TABLE_DEPTH  = 256,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_beat,
	input  in_t   in_data,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int WW = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
	localparam int EW = LEN_W + WW;

	logic [EW-1:0]     mem [TABLE_DEPTH];
	logic [EW-1:0]     rd_s1;
	func_t             func_s1;
	logic              hit_s1;

	logic              hit;
	logic [AW-1:0]     idx;
	logic [LEN_W-1:0]  len_sat;
	logic [WORD_W:0]   lmask;
	logic [WORD_W-1:0] word_m;

	assign hit     = ({1'b0, in_data.symbol} < (SYM_W + 1)'(TABLE_DEPTH));
	assign idx     = in_data.symbol[AW-1:0];
	assign len_sat = (in_data.code_length > LEN_W'(MAX_CODE_LEN)) ?
		LEN_W'(MAX_CODE_LEN) : in_data.code_length;
	assign lmask   = ~({(WORD_W + 1){1'b1}} << len_sat);
	assign word_m  = in_data.code_word & lmask[WORD_W-1:0];

	// Write on load, read on every beat; a load is visible to the next beat.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			if (in_data.func == FUNC_LOAD && hit) begin
				mem[idx] <= {len_sat, word_m[WW-1:0]};
			end
			rd_s1 <= mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			func_s1 <= in_data.func;
			hit_s1  <= hit;
		end
	end

	assign item_s1.func = func_s1;
	assign item_s1.hit  = hit_s1;
	assign item_s1.len  = rd_s1[EW-1 -: LEN_W];
	assign item_s1.word = WORD_W'(rd_s1[WW-1:0]);

endmodule

// ----- design/hcte_packer.sv -----
`timescale 1ns / 1ps

module hcte_packer
	import hcte_pkg::*;
#(
	parameter int MAX_CODE_LEN = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid_s1,
	input  item_t item_s1,
	output logic  advance,
	output logic  out_valid,
	input  logic  out_ready,
	output out_t  out_data
);

	localparam int ACCW = PEND_W + MAX_CODE_LEN;
	localparam int NB   = ACCW / BYTE_W;
	localparam int BUFW = NB * BYTE_W;
	localparam int CNTW = $clog2(ACCW + 1);
	localparam int LW   = $clog2(NB + 1);

	logic [PEND_W-1:0] pend_bits_q;
	logic [PCNT_W-1:0] pend_cnt_q;
	logic [BUFW-1:0]   buf_q;
	logic [LW-1:0]     left_q;

	logic              out_beat;
	logic [ACCW-1:0]   acc;
	logic [ACCW-1:0]   acc_al;
	logic [CNTW-1:0]   count;
	logic [CNTW-1:0]   shamt;
	logic [PEND_W-1:0] rem_mask;
	logic [BYTE_W-1:0] flush_byte;
	logic [BUFW+BYTE_W-1:0] flush_wide;

	logic [BUFW-1:0]   buf_d;
	logic [LW-1:0]     left_d;
	logic [PEND_W-1:0] pend_bits_d;
	logic [PCNT_W-1:0] pend_cnt_d;

	assign out_beat = out_valid && out_ready;
	// Take the next item once the last waiting byte leaves.
	assign advance  = (left_q == '0) || (left_q == LW'(1) && out_ready);

	assign acc      = (ACCW'(pend_bits_q) << item_s1.len) | ACCW'(item_s1.word);
	assign count    = CNTW'(pend_cnt_q) + CNTW'(item_s1.len);
	assign shamt    = CNTW'(ACCW) - count;
	assign acc_al   = acc << shamt;
	assign rem_mask = ~({PEND_W{1'b1}} << count[PCNT_W-1:0]);

	assign flush_byte = BYTE_W'({1'b0, pend_bits_q} << (4'd8 - {1'b0, pend_cnt_q}));
	assign flush_wide = {flush_byte, {BUFW{1'b0}}};

	always_comb begin
		buf_d       = buf_q;
		left_d      = '0;
		pend_bits_d = pend_bits_q;
		pend_cnt_d  = pend_cnt_q;
		unique case (item_s1.func)
			FUNC_ENCODE: begin
				if (item_s1.hit) begin
					buf_d       = acc_al[ACCW-1 -: BUFW];
					left_d      = LW'(count >> 3);
					pend_bits_d = acc[PEND_W-1:0] & rem_mask;
					pend_cnt_d  = count[PCNT_W-1:0];
				end
			end
			FUNC_FLUSH: begin
				if (pend_cnt_q != '0) begin
					buf_d       = flush_wide[BUFW+BYTE_W-1 -: BUFW];
					left_d      = LW'(1);
					pend_bits_d = '0;
					pend_cnt_d  = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (valid_s1 && advance) begin
			left_q      <= left_d;
			pend_bits_q <= pend_bits_d;
			pend_cnt_q  <= pend_cnt_d;
		end else if (out_beat) begin
			left_q <= left_q - LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			buf_q <= buf_d;
		end else if (out_beat) begin
			buf_q <= buf_q << BYTE_W;
		end
	end

	assign out_valid         = (left_q != '0);
	assign out_data.out_byte = buf_q[BUFW-1 -: BYTE_W];
	assign out_data.last     = (left_q == LW'(1));

endmodule

// ----- design/huffman_code_table_encoder.sv -----
`timescale 1ns / 1ps

// Static Huffman encoder with an MSB-first byte packer. A load beat writes one
// symbol's code word and length into the code table (lengths above
// MAX_CODE_LEN saturate); an encode beat appends that symbol's code to the
// pending bits and sends every full byte, earliest bit in the MSB; a flush beat
// sends the partial byte padded with zeros and clears the pending bits. The
// last byte caused by a beat carries last = 1. Loads, unused function codes,
// empty flushes, zero-length codes and symbols beyond the table send nothing.
// Encoding a symbol never loaded gives undefined bytes. Timing: the input
// takes one beat per cycle while in_ready is high into a registered table
// read; the packer then loads all bytes of the item at once and drains one
// byte per cycle while out_ready is high. An item holds the packer until its
// last byte leaves; an item makes at most (7 + MAX_CODE_LEN) / 8 bytes, four
// by default, so the output port sets the sustained rate.
module huffman_code_table_encoder
	import hcte_pkg::*;
#(
	parameter int TABLE_DEPTH  = 256,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic  in_beat;
	logic  advance;
	logic  valid_s1;
	item_t item_s1;

	// Accept whenever the lookup stage is empty or hands its item on this cycle.
	assign in_ready = !valid_s1 || advance;
	assign in_beat  = in_valid && in_ready;

	// Code table and lookup register.
	hcte_table #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_beat  (in_beat),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Bit packer, pending bits and output byte drain.
	hcte_packer #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
